// ===== sv/eic_pkg.sv =====
// ----------------------------------------------------------------------------
// eic_pkg: shared types and constants of the ELF64 image checker
// Payload structs, status codes, format constants and the bounds helper.
// ----------------------------------------------------------------------------
package eic_pkg;

  localparam int PAGE_BITS   = 12;
  localparam int MAX_HEADERS = 32;
  localparam int CNT_W       = 6;
  localparam int ADDR_W      = 5;

  localparam logic [7:0]  ID_MAGIC0    = 8'h7F;
  localparam logic [7:0]  ID_MAGIC1    = 8'h45;
  localparam logic [7:0]  ID_MAGIC2    = 8'h4C;
  localparam logic [7:0]  ID_MAGIC3    = 8'h46;
  localparam logic [7:0]  ELF_CLASS64  = 8'h02;
  localparam logic [7:0]  ELF_DATA_LSB = 8'h01;
  localparam logic [7:0]  ELF_VERSION  = 8'h01;
  localparam logic [15:0] ELF_MACHINE  = 16'd62;
  localparam logic [15:0] ELF_TYPE_EXE = 16'd2;
  localparam logic [15:0] PHDR_SIZE    = 16'd56;
  localparam logic [31:0] MIN_IMAGE    = 32'd64;
  localparam logic [31:0] SEG_LOAD     = 32'd1;
  localparam int          FLAG_WRITE   = 1;

  localparam logic OP_FILE_HDR = 1'b0;
  localparam logic OP_PROG_HDR = 1'b1;

  localparam logic [4:0] ST_OK          = 5'd0;
  localparam logic [4:0] ST_SMALL_IMAGE = 5'd1;
  localparam logic [4:0] ST_BAD_MAGIC   = 5'd2;
  localparam logic [4:0] ST_BAD_CLASS   = 5'd3;
  localparam logic [4:0] ST_BAD_ORDER   = 5'd4;
  localparam logic [4:0] ST_BAD_VERSION = 5'd5;
  localparam logic [4:0] ST_BAD_MACHINE = 5'd6;
  localparam logic [4:0] ST_BAD_TYPE    = 5'd7;
  localparam logic [4:0] ST_BAD_ENTSIZE = 5'd8;
  localparam logic [4:0] ST_NO_HEADERS  = 5'd9;
  localparam logic [4:0] ST_MANY_HDRS   = 5'd10;
  localparam logic [4:0] ST_TABLE_OOB   = 5'd11;
  localparam logic [4:0] ST_SEG_OOB     = 5'd12;
  localparam logic [4:0] ST_SIZE_ORDER  = 5'd13;
  localparam logic [4:0] ST_UNALIGNED   = 5'd14;
  localparam logic [4:0] ST_NO_LOADABLE = 5'd15;
  localparam logic [4:0] ST_ADDR_WRAP   = 5'd16;
  localparam logic [4:0] ST_OUT_WINDOW  = 5'd17;
  localparam logic [4:0] ST_OUT_OF_SEQ  = 5'd18;

  localparam logic [1:0] REG_IMAGE_SIZE = 2'd0;
  localparam logic [1:0] REG_LOAD_LOW   = 2'd1;
  localparam logic [1:0] REG_LOAD_HIGH  = 2'd2;

  typedef struct packed {
    logic        opcode;
    logic [55:0] ident_word;
    logic [15:0] obj_type;
    logic [15:0] machine;
    logic [15:0] entry_size;
    logic [15:0] header_count;
    logic [63:0] file_offset;
    logic [63:0] virt_addr;
    logic [63:0] file_bytes;
    logic [63:0] mem_bytes;
    logic [31:0] seg_type;
    logic [2:0]  seg_flags;
  } in_item_t;

  typedef struct packed {
    logic [4:0]  status;
    logic        done_res;
    logic        accepted;
    logic [63:0] entry_point;
    logic        seg_loadable;
    logic        seg_writable;
    logic [51:0] seg_pages;
  } out_item_t;

  typedef struct packed {
    logic        loadable;
    logic [4:0]  check_code;
    logic [4:0]  range_code;
    logic        writable;
    logic [51:0] pages;
  } seg_res_t;

  // True when [off, off+len) lies within an image of the given size.
  function automatic logic fits_in_image(logic [31:0] size, logic [63:0] off,
                                         logic [63:0] len);
    logic [63:0] size_w;
    size_w = {32'd0, size};
    if (off > size_w) return 1'b0;
    return len <= (size_w - off);
  endfunction

endpackage

// ===== sv/eic_hdr_check.sv =====
// ----------------------------------------------------------------------------
// eic_hdr_check: file header checks
// Gives the first failing check of a file header item, or ST_OK.
// ----------------------------------------------------------------------------
module eic_hdr_check (
  input  eic_pkg::in_item_t item,
  input  logic [31:0]       image_size,
  output logic [4:0]        status
);
  import eic_pkg::*;

  logic [21:0] tbl_size;
  logic [63:0] table_len;

  assign tbl_size  = 22'(item.header_count) * 22'(PHDR_SIZE);
  assign table_len = {42'd0, tbl_size};

  always_comb begin
    if (image_size < MIN_IMAGE) begin
      status = ST_SMALL_IMAGE;
    end else if (item.ident_word[7:0] != ID_MAGIC0 || item.ident_word[15:8] != ID_MAGIC1 ||
                 item.ident_word[23:16] != ID_MAGIC2 ||
                 item.ident_word[31:24] != ID_MAGIC3) begin
      status = ST_BAD_MAGIC;
    end else if (item.ident_word[39:32] != ELF_CLASS64) begin
      status = ST_BAD_CLASS;
    end else if (item.ident_word[47:40] != ELF_DATA_LSB) begin
      status = ST_BAD_ORDER;
    end else if (item.ident_word[55:48] != ELF_VERSION) begin
      status = ST_BAD_VERSION;
    end else if (item.machine != ELF_MACHINE) begin
      status = ST_BAD_MACHINE;
    end else if (item.obj_type != ELF_TYPE_EXE) begin
      status = ST_BAD_TYPE;
    end else if (item.entry_size != PHDR_SIZE) begin
      status = ST_BAD_ENTSIZE;
    end else if (item.header_count == 16'd0) begin
      status = ST_NO_HEADERS;
    end else if (item.header_count > 16'(MAX_HEADERS)) begin
      status = ST_MANY_HDRS;
    end else if (!fits_in_image(image_size, item.file_offset, table_len)) begin
      status = ST_TABLE_OOB;
    end else begin
      status = ST_OK;
    end
  end

endmodule

// ===== sv/eic_seg_check.sv =====
// ----------------------------------------------------------------------------
// eic_seg_check: program header checks
// Classifies one program header and gives its check and range codes.
// ----------------------------------------------------------------------------
module eic_seg_check (
  input  eic_pkg::in_item_t item,
  input  logic [31:0]       image_size,
  input  logic [63:0]       load_low,
  input  logic [63:0]       load_high,
  output eic_pkg::seg_res_t res
);
  import eic_pkg::*;

  logic [63:0] seg_end;
  logic        aligned;

  assign seg_end = item.virt_addr + item.mem_bytes;
  assign aligned = (item.virt_addr[PAGE_BITS-1:0] == '0) &&
                   (item.mem_bytes[PAGE_BITS-1:0] == '0);

  always_comb begin
    res.loadable = (item.seg_type == SEG_LOAD);
    res.writable = res.loadable & item.seg_flags[FLAG_WRITE];
    res.pages    = res.loadable ? item.mem_bytes[63:PAGE_BITS] : 52'd0;

    if (!fits_in_image(image_size, item.file_offset, item.file_bytes)) begin
      res.check_code = ST_SEG_OOB;
    end else if (item.mem_bytes < item.file_bytes) begin
      res.check_code = ST_SIZE_ORDER;
    end else if (!aligned) begin
      res.check_code = ST_UNALIGNED;
    end else begin
      res.check_code = ST_OK;
    end

    if (seg_end < item.virt_addr) begin
      res.range_code = ST_ADDR_WRAP;
    end else if (item.virt_addr < load_low || seg_end > load_high) begin
      res.range_code = ST_OUT_WINDOW;
    end else begin
      res.range_code = ST_OK;
    end
  end

endmodule

// ===== sv/elf64_image_checker_core.sv =====
// ----------------------------------------------------------------------------
// elf64_image_checker_core: streaming ELF64 executable header validator
// Checks a file header item and the program header items that follow it.
// ----------------------------------------------------------------------------
// Items are taken one per clock cycle while the output side keeps up. Each
// accepted transfer lands in an input register, is checked against the image
// state and moves into the result register once that is free or being
// emptied, so each result is presented from the result register. The result
// register and the input register each hold one item, and while a result
// waits the input register can still take one more item, so the rate is one
// item per cycle whenever the output side takes results as they come.
// Registers sit at byte addresses 0 (image_size), 8 (load_low) and 16
// (load_high) of the 64-bit configuration port, which the user must write only
// while no item is in flight; the block itself does not enforce this.
module elf64_image_checker_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  eic_pkg::in_item_t             in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output eic_pkg::out_item_t            out_data,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [eic_pkg::ADDR_W-1:0]    paddr,
  input  logic [63:0]                   pwdata,
  output logic [63:0]                   prdata,
  output logic                          pready
);
  import eic_pkg::*;

  logic [31:0] image_size;
  logic [63:0] load_low;
  logic [63:0] load_high;

  logic       in_vld;
  in_item_t   in_reg;
  logic       advance;

  logic             in_progress, in_progress_next;
  logic [CNT_W-1:0] headers_left, headers_left_next;
  logic [CNT_W-1:0] loadable_seen, loadable_seen_next;
  logic [4:0]       first_check_error, first_check_error_next;
  logic [4:0]       first_range_error, first_range_error_next;
  logic [63:0]      saved_entry, saved_entry_next;
  out_item_t        result_next;

  logic [4:0] hdr_status;
  seg_res_t   seg_res;
  logic [4:0] verdict;
  logic [1:0] reg_index;

  eic_hdr_check u_hdr (
    .item       (in_reg),
    .image_size (image_size),
    .status     (hdr_status)
  );

  eic_seg_check u_seg (
    .item       (in_reg),
    .image_size (image_size),
    .load_low   (load_low),
    .load_high  (load_high),
    .res        (seg_res)
  );

  // Configuration port
  assign pready    = 1'b1;
  assign reg_index = paddr[ADDR_W-1:3];

  always_ff @(posedge clk) begin
    if (rst) begin
      image_size <= '0;
      load_low   <= '0;
      load_high  <= '0;
    end else if (psel && penable && pwrite && pready) begin
      case (reg_index)
        REG_IMAGE_SIZE: image_size <= pwdata[31:0];
        REG_LOAD_LOW:   load_low   <= pwdata;
        REG_LOAD_HIGH:  load_high  <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_index)
      REG_IMAGE_SIZE: prdata = {32'd0, image_size};
      REG_LOAD_LOW:   prdata = load_low;
      REG_LOAD_HIGH:  prdata = load_high;
      default:        prdata = '0;
    endcase
  end

  // Two-register pipeline: an item advances when the result slot is free
  // or is being emptied in the same cycle.
  assign advance  = in_vld && (!out_valid || out_ready);
  assign in_ready = !in_vld || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (in_ready) begin
      in_vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_reg <= in_data;
    end
  end

  always_comb begin
    in_progress_next       = in_progress;
    headers_left_next      = headers_left;
    loadable_seen_next     = loadable_seen;
    first_check_error_next = first_check_error;
    first_range_error_next = first_range_error;
    saved_entry_next       = saved_entry;
    result_next            = '0;
    verdict                = ST_OK;

    if (in_reg.opcode == OP_FILE_HDR) begin
      // A new file header always abandons any open image.
      in_progress_next       = 1'b0;
      headers_left_next      = '0;
      loadable_seen_next     = '0;
      first_check_error_next = ST_OK;
      first_range_error_next = ST_OK;
      saved_entry_next       = '0;
      result_next.status     = hdr_status;
      result_next.done_res   = (hdr_status != ST_OK);
      if (hdr_status == ST_OK) begin
        in_progress_next  = 1'b1;
        headers_left_next = in_reg.header_count[CNT_W-1:0];
        saved_entry_next  = in_reg.virt_addr;
      end
    end else if (!in_progress) begin
      result_next.status = ST_OUT_OF_SEQ;
    end else begin
      if (seg_res.loadable) begin
        loadable_seen_next = loadable_seen + CNT_W'(1);
        if (first_check_error == ST_OK) first_check_error_next = seg_res.check_code;
        if (first_range_error == ST_OK) first_range_error_next = seg_res.range_code;
      end
      result_next.seg_loadable = seg_res.loadable;
      result_next.seg_writable = seg_res.writable;
      result_next.seg_pages    = seg_res.pages;
      headers_left_next        = headers_left - CNT_W'(1);

      if (headers_left_next != '0) begin
        result_next.status = (first_check_error_next != ST_OK) ? first_check_error_next
                                                               : first_range_error_next;
      end else begin
        if (first_check_error_next != ST_OK) verdict = first_check_error_next;
        else if (loadable_seen_next == '0)   verdict = ST_NO_LOADABLE;
        else                                 verdict = first_range_error_next;
        result_next.status   = verdict;
        result_next.done_res = 1'b1;
        if (verdict == ST_OK) begin
          result_next.accepted    = 1'b1;
          result_next.entry_point = saved_entry;
        end
        in_progress_next       = 1'b0;
        loadable_seen_next     = '0;
        first_check_error_next = ST_OK;
        first_range_error_next = ST_OK;
        saved_entry_next       = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_progress       <= 1'b0;
      headers_left      <= '0;
      loadable_seen     <= '0;
      first_check_error <= ST_OK;
      first_range_error <= ST_OK;
      saved_entry       <= '0;
      out_valid         <= 1'b0;
    end else begin
      if (advance) begin
        in_progress       <= in_progress_next;
        headers_left      <= headers_left_next;
        loadable_seen     <= loadable_seen_next;
        first_check_error <= first_check_error_next;
        first_range_error <= first_range_error_next;
        saved_entry       <= saved_entry_next;
        out_valid         <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= result_next;
    end
  end

`ifndef SYNTHESIS
  a_idle_no_count: assert property (@(posedge clk) disable iff (rst)
    !in_progress |-> headers_left == '0)
    else $error("headers pending with no image open");

  a_open_has_count: assert property (@(posedge clk) disable iff (rst)
    in_progress |-> headers_left != '0)
    else $error("image open with no headers pending");

  a_accept_is_final: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.accepted |-> out_data.done_res && out_data.status == ST_OK)
    else $error("accepted result without a clean final verdict");

  a_out_of_seq: assert property (@(posedge clk) disable iff (rst)
    advance && in_reg.opcode == OP_PROG_HDR && !in_progress
      |=> out_valid && out_data.status == ST_OUT_OF_SEQ && !out_data.seg_loadable)
    else $error("stray program header not flagged");
`endif

endmodule
